// File: hw/rtl/adps_pkg.sv
// ----------------------------------------------------------------------------
// adps_pkg
// Types, constants and pixel functions shared by the posterized difference
// sharpen block.
// ----------------------------------------------------------------------------
package adps_pkg;

    localparam int PIX_W        = 8;
    localparam int CODE_W       = 2;
    localparam int ROW_W        = 16;
    localparam int COL_W        = 12;
    localparam int WIDTH_REG_W  = 13;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int MAX_LINE_DEF = 4096;
    localparam int SUM_W        = 12;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 13'd4096;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd2160;

    localparam logic [PIX_W-1:0] LOW_THRESH  = 8'd32;
    localparam logic [PIX_W-1:0] HIGH_THRESH = 8'd96;
    localparam logic [PIX_W-1:0] MID_VALUE   = 8'd128;
    localparam logic [PIX_W-1:0] FULL_VALUE  = 8'd255;
    localparam logic [SUM_W-1:0] CENTER_GAIN = 12'd5;

    typedef enum logic [CODE_W-1:0] {
        CODE_ZERO = 2'd0,
        CODE_MID  = 2'd1,
        CODE_FULL = 2'd2
    } code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    function automatic code_t posterize(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        if (d < LOW_THRESH) begin
            return CODE_ZERO;
        end
        if (d < HIGH_THRESH) begin
            return CODE_MID;
        end
        return CODE_FULL;
    endfunction

    function automatic logic [PIX_W-1:0] code_value(code_t c);
        logic [PIX_W-1:0] v;
        case (c)
            CODE_ZERO: v = '0;
            CODE_MID:  v = MID_VALUE;
            default:   v = FULL_VALUE;
        endcase
        return v;
    endfunction

    // 5 * center minus the four neighbours, clipped to 0..255
    function automatic logic [PIX_W-1:0] sharpen(
        logic [PIX_W-1:0] center,
        logic [PIX_W-1:0] top,
        logic [PIX_W-1:0] bottom,
        logic [PIX_W-1:0] left,
        logic [PIX_W-1:0] right
    );
        logic [SUM_W-1:0] acc;
        acc = SUM_W'(center) * CENTER_GAIN - SUM_W'(top) - SUM_W'(bottom)
            - SUM_W'(left) - SUM_W'(right);
        if (acc[SUM_W-1]) begin
            return '0;
        end
        if (acc > SUM_W'(FULL_VALUE)) begin
            return FULL_VALUE;
        end
        return acc[PIX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/abs_diff_posterize_sharpen.sv
// ----------------------------------------------------------------------------
// abs_diff_posterize_sharpen
// Posterized absolute difference of two images followed by a 3x3 cross
// sharpen over two line stores of 2-bit codes.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per cycle in raster order while s_ready is
// high. At the accepting edge the pair is posterized, written into the line
// store of its row parity and both line stores are read; the filter stage
// forms the cross filter of the pixel above and loads it into the free output
// register. Rows above the last give one result beat per pair and sustain one
// pair per cycle while the output is not stalled; pairs of the last row give
// two beats and, through the single output port, hold off the next pair until
// one of them is taken. Row 0 gives no beats unless it is also the last row.
// The line stores need no clearing after reset. Width and height must be
// written only while the block is idle, unchecked by the block; a width of 0
// acts as 1 and a width above MAX_LINE as MAX_LINE, a height of 0 acts as 1.
// ----------------------------------------------------------------------------
module abs_diff_posterize_sharpen #(
    parameter int MAX_LINE = adps_pkg::MAX_LINE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [adps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [adps_pkg::PIX_W-1:0]        s_pixel_a,
    input  logic [adps_pkg::PIX_W-1:0]        s_pixel_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [adps_pkg::PIX_W-1:0]        m_pixel_out,
    output logic [adps_pkg::ROW_W-1:0]        m_out_row,
    output logic [adps_pkg::COL_W-1:0]        m_out_col,
    output logic                              m_last_of_run
);

    import adps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int XW     = (ADDR_W + 1 > WIDTH_REG_W) ? ADDR_W + 1 : WIDTH_REG_W;
    localparam int CW     = (ADDR_W > COL_W) ? ADDR_W : COL_W;

    // configuration
    logic [WIDTH_REG_W-1:0] image_width_reg;
    logic [ROW_W-1:0]       image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    logic [XW-1:0]    width_x;
    logic [XW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        width_x = XW'(image_width_reg);
        if (width_x == '0) begin
            w_eff = XW'(1);
        end else if (width_x > XW'(MAX_LINE)) begin
            w_eff = XW'(MAX_LINE);
        end else begin
            w_eff = width_x;
        end
        h_eff = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
    end

    // position of the incoming beat
    logic [CW-1:0]    column_count_reg, column_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    logic             accept;
    logic             col_wrap;
    logic [CW-1:0]    col;
    logic [ROW_W:0]   row_pre;
    logic [ROW_W-1:0] row;
    logic [XW-1:0]    col_x;
    logic [XW-1:0]    col1_x;
    logic             end_of_row;
    logic [ROW_W:0]   row1;
    code_t            code_in;

    assign accept = s_valid && s_ready;

    always_comb begin
        col_wrap = XW'(column_count_reg) >= w_eff;
        col      = col_wrap ? '0 : column_count_reg;
        row_pre  = col_wrap ? ({1'b0, row_count_reg} + 1'b1) : {1'b0, row_count_reg};
        row      = (row_pre >= {1'b0, h_eff}) ? '0 : row_pre[ROW_W-1:0];
        col_x      = XW'(col);
        col1_x     = col_x + 1'b1;
        end_of_row = col1_x >= w_eff;
        row1       = {1'b0, row} + 1'b1;
        code_in    = posterize(s_pixel_a, s_pixel_b);

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept) begin
            if (end_of_row) begin
                column_count_next = '0;
                row_count_next    = (row1 >= {1'b0, h_eff}) ? '0 : row1[ROW_W-1:0];
            end else begin
                column_count_next = col1_x[CW-1:0];
                row_count_next    = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // line stores: current row written, both read at the accepting edge
    logic [ADDR_W-1:0] addr_col;
    logic [ADDR_W-1:0] addr_right;
    logic              row_odd;
    logic [CODE_W-1:0] even_rd_a, even_rd_b, odd_rd_a, odd_rd_b;

    assign addr_col   = col_x[ADDR_W-1:0];
    assign addr_right = col1_x[ADDR_W-1:0];
    assign row_odd    = row[0];

    adps_line_store #(
        .DEPTH  (MAX_LINE),
        .ADDR_W (ADDR_W),
        .DATA_W (CODE_W)
    ) u_store_even (
        .aclk      (aclk),
        .wr_en     (accept && !row_odd),
        .wr_addr   (addr_col),
        .wr_data   (code_in),
        .rd_en     (accept),
        .rd_addr_a (row_odd ? '0 : addr_col),
        .rd_addr_b (addr_right),
        .rd_data_a (even_rd_a),
        .rd_data_b (even_rd_b)
    );

    adps_line_store #(
        .DEPTH  (MAX_LINE),
        .ADDR_W (ADDR_W),
        .DATA_W (CODE_W)
    ) u_store_odd (
        .aclk      (aclk),
        .wr_en     (accept && row_odd),
        .wr_addr   (addr_col),
        .wr_data   (code_in),
        .rd_en     (accept),
        .rd_addr_a (row_odd ? addr_col : '0),
        .rd_addr_b (addr_right),
        .rd_data_a (odd_rd_a),
        .rd_data_b (odd_rd_b)
    );

    // filter stage
    logic             s1_valid_reg, s1_valid_next;
    code_t            s1_code_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_odd_reg;
    logic             s1_col0_reg;
    logic             s1_right_reg;
    logic             s1_border_reg;
    logic             s1_prev_reg;
    logic             s1_last_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_code_reg   <= code_in;
            s1_col_reg    <= col[COL_W-1:0];
            s1_row_reg    <= row;
            s1_odd_reg    <= row_odd;
            s1_col0_reg   <= (col == '0);
            s1_right_reg  <= !end_of_row;
            s1_border_reg <= (row == ROW_W'(1)) || (col == '0) || end_of_row;
            s1_prev_reg   <= (row != '0);
            s1_last_reg   <= (row == h_eff - 1'b1);
        end
    end

    code_t win1_reg, win2_reg;
    code_t win0_next, win1_next, win2_next;
    code_t top_code, prev0_code, prevr_code;
    logic [PIX_W-1:0] center_pix;
    logic [PIX_W-1:0] filt_pix;

    logic             out0_v_reg, out0_v_next;
    logic             out1_v_reg, out1_v_next;
    logic [PIX_W-1:0] out0_pix_reg, out1_pix_reg;
    logic [ROW_W-1:0] out0_row_reg, out1_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             out_free;
    logic             s1_adv;

    always_comb begin
        top_code   = code_t'(s1_odd_reg ? odd_rd_a : even_rd_a);
        prev0_code = code_t'(s1_odd_reg ? even_rd_a : odd_rd_a);
        prevr_code = code_t'(s1_odd_reg ? even_rd_b : odd_rd_b);

        // window of the row above, centered on this column
        win0_next = s1_col0_reg ? CODE_ZERO : win1_reg;
        win1_next = s1_col0_reg ? prev0_code : win2_reg;
        win2_next = s1_right_reg ? prevr_code : CODE_ZERO;

        center_pix = code_value(win1_next);
        if (s1_border_reg) begin
            filt_pix = center_pix;
        end else begin
            filt_pix = sharpen(center_pix, code_value(top_code), code_value(s1_code_reg),
                               code_value(win0_next), code_value(win2_next));
        end

        out_free = !((out0_v_reg && out1_v_reg) || ((out0_v_reg || out1_v_reg) && !m_ready));
        s1_adv   = s1_valid_reg && out_free;
        s_ready  = !s1_valid_reg || s1_adv;

        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

        out0_v_next = out0_v_reg;
        out1_v_next = out1_v_reg;
        if (s1_adv) begin
            out0_v_next = s1_prev_reg;
            out1_v_next = s1_last_reg;
        end else if (m_valid && m_ready) begin
            if (out0_v_reg) begin
                out0_v_next = 1'b0;
            end else begin
                out1_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            out0_v_reg   <= 1'b0;
            out1_v_reg   <= 1'b0;
            win1_reg     <= CODE_ZERO;
            win2_reg     <= CODE_ZERO;
        end else begin
            s1_valid_reg <= s1_valid_next;
            out0_v_reg   <= out0_v_next;
            out1_v_reg   <= out1_v_next;
            if (s1_adv) begin
                win1_reg <= win1_next;
                win2_reg <= win2_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out0_pix_reg <= filt_pix;
            out0_row_reg <= s1_row_reg - 1'b1;
            out1_pix_reg <= code_value(s1_code_reg);
            out1_row_reg <= s1_row_reg;
            out_col_reg  <= s1_col_reg;
        end
    end

    assign m_valid       = out0_v_reg || out1_v_reg;
    assign m_pixel_out   = out0_v_reg ? out0_pix_reg : out1_pix_reg;
    assign m_out_row     = out0_v_reg ? out0_row_reg : out1_row_reg;
    assign m_out_col     = out_col_reg;
    assign m_last_of_run = !(out0_v_reg && out1_v_reg);

    // a full filter stage behind a stalled output must hold off the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while filter stage is blocked");

    // results only appear after the filter stage held a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s1_valid_reg))
        else $error("result beat without a filtered beat");

    // the pass-through beat sits one row below the filtered beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out0_v_reg && out1_v_reg) |-> (out1_row_reg == out0_row_reg + 1'b1))
        else $error("result pair rows out of step");

endmodule

// File: hw/rtl/adps_line_store.sv
// ----------------------------------------------------------------------------
// adps_line_store
// One row of posterized codes: one write port and two read ports with
// registered read data, read before write at the same address.
// ----------------------------------------------------------------------------
module adps_line_store #(
    parameter int DEPTH  = adps_pkg::MAX_LINE_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = adps_pkg::CODE_W
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_a_reg;
    logic [DATA_W-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for abs_diff_posterize_sharpen. Pixel pairs are pushed
// through a valid/ready driver. A predictor posterizes each difference,
// keeps its own copy of the line codes and the 3x3 cross window, and queues
// the result beats it expects. A monitor pops that queue and compares every
// field. Directed frames cover the thresholds, clipping, zero sizes, a width
// above the line depth and shrinking sizes in mid frame. Random frames of
// small sizes follow, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import adps_pkg::*;

    localparam int LINE_DEPTH     = MAX_LINE_DEF;
    localparam int RANDOM_PAIRS   = 850;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_STALL     = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
    } pair_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } beat_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel_a     = '0;
    logic [PIX_W-1:0]      s_pixel_b     = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [PIX_W-1:0]      m_pixel_out;
    logic [ROW_W-1:0]      m_out_row;
    logic [COL_W-1:0]      m_out_col;
    logic                  m_last_of_run;

    // predictor state
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    code_t                  even_codes [LINE_DEPTH];
    code_t                  odd_codes  [LINE_DEPTH];
    code_t                  window     [3];
    int                     col_pos;
    int                     row_pos;

    pair_t pair_backlog    [$];
    beat_t predicted_beats [$];

    int pairs_queued   = 0;
    int pairs_taken    = 0;
    int beats_checked  = 0;
    int err_cnt        = 0;
    int reg_writes     = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int src_gap        = 0;
    int sink_wait      = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int quiet_cycles   = 0;

    abs_diff_posterize_sharpen dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_a     (s_pixel_a),
        .s_pixel_b     (s_pixel_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_of_run (m_last_of_run)
    );

    always #4 aclk = ~aclk;

    function automatic int code_level(code_t c);
        case (c)
            CODE_ZERO: return 0;
            CODE_MID:  return 128;
            default:   return 255;
        endcase
    endfunction

    function automatic code_t line_code(logic odd, int idx);
        return odd ? odd_codes[idx] : even_codes[idx];
    endfunction

    function automatic void posterize_and_sharpen(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        int    w;
        int    h;
        int    col;
        int    row;
        int    diff;
        int    acc;
        logic  prev_odd;
        code_t code;
        beat_t one;
        beat_t out_beats [$];
        w = (width_reg == 0) ? 1 : int'(width_reg);
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = (height_reg == 0) ? 1 : int'(height_reg);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        col = col_pos;
        row = row_pos;

        diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        if (diff < 32) begin
            code = CODE_ZERO;
        end else if (diff < 96) begin
            code = CODE_MID;
        end else begin
            code = CODE_FULL;
        end
        prev_odd = !row[0];

        // slide the window over the row above
        if (col == 0) begin
            window[0] = CODE_ZERO;
            window[1] = line_code(prev_odd, 0);
        end else begin
            window[0] = window[1];
            window[1] = window[2];
        end
        window[2] = (col + 1 < w) ? line_code(prev_odd, col + 1) : CODE_ZERO;

        if (row >= 1) begin
            if (row == 1 || col == 0 || col == w - 1) begin
                acc = code_level(window[1]);
            end else begin
                acc = 5 * code_level(window[1]) - code_level(line_code(row[0], col))
                    - code_level(code) - code_level(window[0]) - code_level(window[2]);
                if (acc < 0) acc = 0;
                if (acc > 255) acc = 255;
            end
            one.pix  = PIX_W'(acc);
            one.row  = ROW_W'(row - 1);
            one.col  = COL_W'(col);
            one.last = 1'b0;
            out_beats.push_back(one);
        end

        if (row[0]) begin
            odd_codes[col] = code;
        end else begin
            even_codes[col] = code;
        end

        if (row == h - 1) begin
            one.pix  = PIX_W'(code_level(code));
            one.row  = ROW_W'(row);
            one.col  = COL_W'(col);
            one.last = 1'b0;
            out_beats.push_back(one);
        end

        if (out_beats.size() > 0) out_beats[out_beats.size() - 1].last = 1'b1;
        foreach (out_beats[k]) predicted_beats.push_back(out_beats[k]);

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // spread the differences over all three code bands
    function automatic pair_t random_pair();
        int    d;
        int    lo;
        pair_t p;
        case ($urandom_range(3))
            0: d = $urandom_range(31);
            1: d = $urandom_range(95, 32);
            2: d = $urandom_range(255, 96);
            default: begin
                p.a = PIX_W'($urandom_range(255));
                p.b = PIX_W'($urandom_range(255));
                return p;
            end
        endcase
        lo = $urandom_range(255 - d);
        if ($urandom_range(1) == 1) begin
            p.a = PIX_W'(lo);
            p.b = PIX_W'(lo + d);
        end else begin
            p.a = PIX_W'(lo + d);
            p.b = PIX_W'(lo);
        end
        return p;
    endfunction

    task automatic queue_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
        pair_backlog.push_back({a, b});
        pairs_queued++;
    endtask

    task automatic queue_random(input int count);
        pair_t p;
        for (int i = 0; i < count; i++) begin
            p = random_pair();
            queue_pair(p.a, p.b);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
        end else begin
            height_reg = data;
        end
        reg_writes++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pairs_taken != pairs_queued || predicted_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // pair driver
    always @(posedge aclk) begin : pair_driver
        pair_t next_pair;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_pixel_a <= '0;
            s_pixel_b <= '0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                posterize_and_sharpen(s_pixel_a, s_pixel_b);
                pairs_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pair_backlog.size() > 0) begin
                    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
                        src_gap = $urandom_range(16);
                        s_valid <= 1'b0;
                    end else begin
                        next_pair = pair_backlog.pop_front();
                        s_valid   <= 1'b1;
                        s_pixel_a <= next_pair.a;
                        s_pixel_b <= next_pair.b;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            sink_wait = LONG_STALL - 1;
            m_ready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_ready <= 1'b0;
        end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
            sink_wait = $urandom_range(16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin : beat_monitor
        beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_beats.size() == 0) begin
                $error("result beat with nothing predicted: row %0d col %0d",
                       m_out_row, m_out_col);
                err_cnt++;
            end else begin
                want = predicted_beats.pop_front();
                beats_checked++;
                if (m_pixel_out !== want.pix) begin
                    $error("pixel_out: expected %0d, got %0d", want.pix, m_pixel_out);
                    err_cnt++;
                end
                if (m_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, m_out_row);
                    err_cnt++;
                end
                if (m_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, m_out_col);
                    err_cnt++;
                end
                if (m_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any beat or register write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : sequencer
        int i;
        int w;
        int h;
        int n;
        int half;
        int phase;
        int random_pairs;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        col_pos    = 0;
        row_pos    = 0;
        for (i = 0; i < 3; i++) window[i] = CODE_ZERO;
        for (i = 0; i < LINE_DEPTH; i++) begin
            even_codes[i] = CODE_ZERO;
            odd_codes[i]  = CODE_ZERO;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_pct  = 20;
        sink_idle_pct = 20;

        // zero sizes act as one pixel: posterize thresholds
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        queue_pair(8'd0, 8'd0);
        queue_pair(8'd255, 8'd0);
        queue_pair(8'd0, 8'd255);
        queue_pair(8'd31, 8'd0);
        queue_pair(8'd0, 8'd32);
        queue_pair(8'd95, 8'd0);
        queue_pair(8'd0, 8'd96);
        queue_pair(8'd170, 8'd85);
        wait_drained();

        // 3x3 frames: clip high then clip low at the center
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        for (i = 0; i < 9; i++) queue_pair((i == 4) ? 8'd255 : 8'd0, 8'd0);
        for (i = 0; i < 9; i++) queue_pair((i == 4) ? 8'd0 : 8'd255, 8'd0);
        wait_drained();

        // width above the line depth, a single row passes straight through
        write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        queue_random(20);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        queue_random(1);
        wait_drained();

        // width shrunk in mid row wraps the column
        write_reg(REG_IMAGE_WIDTH, 16'd6);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        queue_random(9);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        queue_random(3);
        wait_drained();

        // tallest frame, cut short by a smaller height
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        queue_random(12);
        wait_drained();
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        queue_random(8);
        wait_drained();

        // random frames of small sizes
        phase = 0;
        random_pairs = 0;
        while (random_pairs < RANDOM_PAIRS) begin
            if (RANDOM_PAIRS - random_pairs <= QUIET_TAIL) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(30, 5);
                sink_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(30, 5);
            end
            w = ($urandom_range(5) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            n = w * h * ((w > 12) ? 1 : $urandom_range(3, 1));
            if (phase == 1) begin
                w = 10;
                h = 6;
                n = 60;
                src_idle_pct = 0;
            end
            if (phase == 3) begin
                w = 7;
                h = 5;
                n = 70;
            end
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            if (phase == 3) begin
                // sender pauses until every result is back
                half = n / 2;
                queue_random(half);
                wait_drained();
                queue_random(n - half);
            end else begin
                queue_random(n);
                // long receiver hold while pairs keep coming
                if (phase == 1) stall_requests++;
            end
            wait_drained();
            random_pairs += n;
            phase++;
        end

        $display("covered %0d pixel pairs over %0d register writes and %0d random frame sets",
                 pairs_taken, reg_writes, phase);
        $display("including zero, saturated and mid-frame shrunk sizes; %0d result beats checked",
                 beats_checked);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: abs_diff_posterize_sharpen.f
hw/rtl/adps_pkg.sv
hw/rtl/adps_line_store.sv
hw/rtl/abs_diff_posterize_sharpen.sv
bench/tb_top.sv
